@@ design/mfp_pkg.sv @@
`timescale 1ns / 1ps
package mfp_pkg;

  // frame layout
  localparam int unsigned FrameBody  = 9;
  localparam int unsigned FrameTotal = 10;
  localparam logic [7:0]  CrcPoly    = 8'h8C;

  // input kinds carried on tuser
  localparam logic ActByte = 1'b0;
  localparam logic ActIdle = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  // one result item from the frame assembler
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [7:0]         motor_id;
    logic [7:0]         drive_mode;
    logic signed [15:0] current_raw;
    logic signed [15:0] speed_rpm;
    logic [15:0]        angle_raw;
    logic [7:0]         fault_code;
    logic [3:0]         byte_total;
  } result_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data_in;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

@@ design/mfp_frame_asm.sv @@
`timescale 1ns / 1ps
module mfp_frame_asm
  import mfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       action_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  logic [3:0] idx_q, idx_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] store_q [FrameBody];
  logic       store_we;

  // decode the held item against the frame state
  always_comb begin
    idx_d    = idx_q;
    crc_d    = crc_q;
    store_we = 1'b0;
    res_o    = '0;
    res_o.status = ST_OK;
    if (action_i == ActIdle) begin
      // idle line ends a partial frame
      if (idx_q != 4'd0) begin
        res_o.valid      = 1'b1;
        res_o.status     = ST_SHORT;
        res_o.byte_total = idx_q;
        idx_d            = 4'd0;
        crc_d            = 8'd0;
      end
    end else if (idx_q < 4'(FrameBody)) begin
      // body byte: store and fold into crc
      store_we = 1'b1;
      crc_d    = crc8_feed(crc_q, byte_i);
      idx_d    = idx_q + 4'd1;
    end else begin
      // check byte closes the frame
      res_o.valid       = 1'b1;
      res_o.status      = (byte_i == crc_q) ? ST_OK : ST_CRC_ERR;
      res_o.motor_id    = store_q[0];
      res_o.drive_mode  = store_q[1];
      res_o.current_raw = {store_q[2], store_q[3]};
      res_o.speed_rpm   = {store_q[4], store_q[5]};
      res_o.angle_raw   = {store_q[6], store_q[7]};
      res_o.fault_code  = store_q[8];
      res_o.byte_total  = 4'(FrameTotal);
      idx_d             = 4'd0;
      crc_d             = 8'd0;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      crc_q <= 8'd0;
    end else if (step_i) begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  // frame body bytes
  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      store_q[idx_q] <= byte_i;
    end
  end

endmodule

@@ design/motor_feedback_frame_parser.sv @@
`timescale 1ns / 1ps
// Motor feedback frame parser. Each input item is either a received byte
// (tuser 0) or an idle-line mark (tuser 1). Ten bytes make a frame; the
// running CRC-8 (reflected, poly 0x8C, init 0) over bytes 0..8 is checked
// against byte 9 and one result item gives the raw fields with status ok
// or CRC error. An idle mark after 1..9 bytes gives a short-frame result
// with zero fields and restarts assembly; idle with nothing pending gives
// nothing. One item is accepted per cycle at full rate; a result item is
// presented on the output once its input item has passed the input
// register, then the result register; the whole per-byte CRC update is
// combinational between them. The input stalls only while a result
// waits unaccepted and the held input item would produce another result.
// No clearing pass is needed after reset.
module motor_feedback_frame_parser
  import mfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] motor_id, [15:8] drive_mode, [31:16] current_raw,
  // [47:32] speed_rpm, [63:48] angle_raw, [71:64] fault_code,
  // [75:72] byte_total, [79:76] zero
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  logic       in_vld_q;
  logic       in_act_q;
  logic [7:0] in_byte_q;
  logic       advance;
  result_t    res;
  logic        out_vld_q;
  logic [79:0] out_data_q;
  status_e     out_stat_q;

  // input stage moves on unless its result would hit a full output
  assign advance       = in_vld_q && (!res.valid || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_act_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  mfp_frame_asm u_asm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .action_i (in_act_q),
    .byte_i   (in_byte_q),
    .res_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_stat_q <= res.status;
      out_data_q <= {4'd0, res.byte_total, res.fault_code, res.angle_raw,
                     res.speed_rpm, res.current_raw, res.drive_mode,
                     res.motor_id};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

@@ design/mfp_checker.sv @@
`timescale 1ns / 1ps
module mfp_checker
  import mfp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // short frame carries a count of 1..9 and zero fields
  a_short_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_SHORT |->
      m_axis_tdata[75:72] != 4'd0 && m_axis_tdata[75:72] < 4'(FrameTotal) &&
      m_axis_tdata[71:0] == '0)
    else $error("bad short frame result");

  // complete frames always count ten bytes
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OK || m_axis_tuser == ST_CRC_ERR) |->
      m_axis_tdata[75:72] == 4'(FrameTotal))
    else $error("bad byte count on full frame");

  // no undefined status code and zero padding
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3 && m_axis_tdata[79:76] == 4'd0)
    else $error("bad status or padding");

  // input is open whenever the output is free or draining
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input blocked with free output");

endmodule

bind motor_feedback_frame_parser mfp_checker u_mfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
